[hdl/csalu_pkg.sv]
// shared types and constants for the checked signed alu
// no dependencies
package csalu_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = DataW / 2;
	localparam int unsigned InTdataW = 136;
	localparam int unsigned OutTdataW = 72;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	// fields that ride alongside the divider stages
	typedef struct packed {
		logic [DataW-1:0] val;
		status_t          st;
		logic             is_div;
		logic             neg;
	} side_t;

endpackage

[hdl/checked_signed_alu_unit.sv]
// top level of the overflow checked signed 64-bit alu
// depends on csalu_pkg and csalu_div_pipe
//
// Fully pipelined: one beat is accepted every cycle and each result appears
// in order. The divider, which resolves one quotient bit per stage over 64
// stages, makes up most of the pipeline; add, subtract and multiply travel
// alongside it. A stall on the output holds the whole pipeline. Multiply uses
// four registered 32x32 partial products.
module checked_signed_alu_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// mode[1:0], lhs[65:2], rhs[129:66], zero fill
	input  logic [csalu_pkg::InTdataW-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// value[63:0], status[65:64], zero fill
	output logic [csalu_pkg::OutTdataW-1:0]   m_tdata
);

	localparam int unsigned W = csalu_pkg::DataW;
	localparam int unsigned H = csalu_pkg::HalfW;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// input decode
	csalu_pkg::mode_t mode_in;
	logic [W-1:0] a, b, sum, dif, ma, mb;
	csalu_pkg::status_t st_in;
	logic [W-1:0] val_in;
	assign mode_in = csalu_pkg::mode_t'(s_tdata[1:0]);
	assign a   = s_tdata[W+1:2];
	assign b   = s_tdata[2*W+1:W+2];
	assign sum = a + b;
	assign dif = a - b;
	assign ma  = a[W-1] ? (W'(0) - a) : a;
	assign mb  = b[W-1] ? (W'(0) - b) : b;

	always_comb begin
		st_in  = csalu_pkg::ST_OK;
		val_in = '0;
		unique case (mode_in)
			csalu_pkg::MODE_ADD: begin
				val_in = sum;
				if ((a[W-1] ^ sum[W-1]) & (b[W-1] ^ sum[W-1])) st_in = csalu_pkg::ST_OVF;
			end
			csalu_pkg::MODE_SUB: begin
				val_in = dif;
				if ((a[W-1] ^ b[W-1]) & (a[W-1] ^ dif[W-1])) st_in = csalu_pkg::ST_OVF;
			end
			csalu_pkg::MODE_MUL: begin
				st_in = csalu_pkg::ST_OK;
			end
			csalu_pkg::MODE_DIV: begin
				if (b == '0) st_in = csalu_pkg::ST_DIVZ;
				else if (a == {1'b1, {(W-1){1'b0}}} && b == '1) st_in = csalu_pkg::ST_OVF;
			end
		endcase
	end

	// stage 1
	logic               vld_s1, neg_s1;
	csalu_pkg::mode_t   mode_s1;
	csalu_pkg::status_t st_s1;
	logic [W-1:0]       val_s1, ma_s1, mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_in;
			st_s1   <= st_in;
			val_s1  <= val_in;
			ma_s1   <= ma;
			mb_s1   <= mb;
			neg_s1  <= a[W-1] ^ b[W-1];
		end
	end

	// stage 2: partial products
	logic               vld_s2, neg_s2;
	csalu_pkg::mode_t   mode_s2;
	csalu_pkg::status_t st_s2;
	logic [W-1:0]       val_s2, ma_s2, mb_s2;
	logic [W-1:0]       p00_s2, p01_s2, p10_s2, p11_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			st_s2   <= st_s1;
			val_s2  <= val_s1;
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			neg_s2  <= neg_s1;
			p00_s2  <= ma_s1[H-1:0] * mb_s1[H-1:0];
			p01_s2  <= ma_s1[H-1:0] * mb_s1[W-1:H];
			p10_s2  <= ma_s1[W-1:H] * mb_s1[H-1:0];
			p11_s2  <= ma_s1[W-1:H] * mb_s1[W-1:H];
		end
	end

	// stage 3: product assembly
	logic [H+2:0] mid;
	assign mid = (H+3)'(p00_s2[W-1:H]) + (H+3)'(p01_s2[H-1:0]) + (H+3)'(p10_s2[H-1:0]);

	logic               vld_s3, neg_s3;
	csalu_pkg::mode_t   mode_s3;
	csalu_pkg::status_t st_s3;
	logic [W-1:0]       val_s3, ma_s3, mb_s3, lo_s3, hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			st_s3   <= st_s2;
			val_s3  <= val_s2;
			ma_s3   <= ma_s2;
			mb_s3   <= mb_s2;
			neg_s3  <= neg_s2;
			lo_s3   <= {mid[H-1:0], p00_s2[H-1:0]};
			hi_s3   <= p11_s2 + W'(p01_s2[W-1:H]) + W'(p10_s2[W-1:H]) + W'(mid[H+2:H]);
		end
	end

	// stage 4: multiply range check, feed divider
	csalu_pkg::side_t side_in;
	logic [W-1:0] lim;
	assign lim = neg_s3 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

	always_comb begin
		side_in.val    = val_s3;
		side_in.st     = st_s3;
		side_in.is_div = (mode_s3 == csalu_pkg::MODE_DIV);
		side_in.neg    = neg_s3;
		if (mode_s3 == csalu_pkg::MODE_MUL) begin
			side_in.val = neg_s3 ? (W'(0) - lo_s3) : lo_s3;
			if (hi_s3 != '0 || lo_s3 > lim) side_in.st = csalu_pkg::ST_OVF;
		end
	end

	logic             div_vld;
	logic [W-1:0]     quo;
	csalu_pkg::side_t side_out;

	csalu_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.dividend (ma_s3),
		.divisor  (mb_s3),
		.side_in  (side_in),
		.out_vld  (div_vld),
		.quotient (quo),
		.side_out (side_out)
	);

	// output register
	logic [W-1:0] res;
	always_comb begin
		res = side_out.val;
		if (side_out.is_div) res = side_out.neg ? (W'(0) - quo) : quo;
		if (side_out.st != csalu_pkg::ST_OK) res = '0;
	end

	logic               vld_q;
	logic [W-1:0]       val_q;
	csalu_pkg::status_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= res;
			st_q  <= side_out.st;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {6'b0, st_q, val_q};

	a_no_status3: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[65:64] != 2'd3)
		else $error("reserved status code on output");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65:64] != csalu_pkg::ST_OK |-> m_tdata[63:0] == '0)
		else $error("nonzero value with failing status");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

[hdl/csalu_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on csalu_pkg
module csalu_div_pipe (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic [csalu_pkg::DataW-1:0]     dividend,
	input  logic [csalu_pkg::DataW-1:0]     divisor,
	input  csalu_pkg::side_t                side_in,
	output logic                            out_vld,
	output logic [csalu_pkg::DataW-1:0]     quotient,
	output csalu_pkg::side_t                side_out
);

	localparam int unsigned W = csalu_pkg::DataW;

	logic             vld_s  [0:W];
	logic [W-1:0]     rem_s  [0:W];
	logic [W-1:0]     quo_s  [0:W];
	logic [W-1:0]     dvs_s  [0:W];
	csalu_pkg::side_t side_s [0:W];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = dividend;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		assign trial = {rem_s[k], quo_s[k][W-1]};
		assign diff  = trial - {1'b0, dvs_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[W]) begin
					rem_s[k+1] <= diff[W-1:0];
					quo_s[k+1] <= {quo_s[k][W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial[W-1:0];
					quo_s[k+1] <= {quo_s[k][W-2:0], 1'b0};
				end
				dvs_s[k+1]  <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[W];
	assign quotient = quo_s[W];
	assign side_out = side_s[W];

endmodule

[sim/tb_top.sv]
// self-checking testbench for checked_signed_alu_unit
// predicts each result from the operands and compares beats in order
// depends on csalu_pkg and the alu rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0]        value;
		csalu_pkg::status_t status;
	} alu_result_t;

	class alu_scoreboard;
		alu_result_t pending[$];
		int errors;

		function alu_result_t compute(csalu_pkg::mode_t mode, logic [63:0] a, logic [63:0] b);
			alu_result_t r;
			logic [63:0] s;
			logic signed [127:0] prod;
			logic [63:0] ma;
			logic [63:0] mb;
			logic [63:0] q;
			r.value = '0;
			r.status = csalu_pkg::ST_OK;
			case (mode)
				csalu_pkg::MODE_ADD: begin
					s = a + b;
					if (a[63] == b[63] && s[63] != a[63]) r.status = csalu_pkg::ST_OVF;
					else r.value = s;
				end
				csalu_pkg::MODE_SUB: begin
					s = a - b;
					if (a[63] != b[63] && s[63] != a[63]) r.status = csalu_pkg::ST_OVF;
					else r.value = s;
				end
				csalu_pkg::MODE_MUL: begin
					prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
					if (prod[127:63] != {65{prod[63]}}) r.status = csalu_pkg::ST_OVF;
					else r.value = prod[63:0];
				end
				default: begin
					if (b == '0) r.status = csalu_pkg::ST_DIVZ;
					else if (a == 64'h8000000000000000 && b == '1) r.status = csalu_pkg::ST_OVF;
					else begin
						ma = a[63] ? -a : a;
						mb = b[63] ? -b : b;
						q = ma / mb;
						r.value = (a[63] ^ b[63]) ? -q : q;
					end
				end
			endcase
			return r;
		endfunction

		function void note_operation(csalu_pkg::mode_t mode, logic [63:0] a, logic [63:0] b);
			pending.push_back(compute(mode, a, b));
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		task check_result(logic [63:0] value, logic [1:0] status);
			alu_result_t e;
			if (pending.size() == 0) begin
				report("unexpected beat", value, 0);
				return;
			end
			e = pending.pop_front();
			if (status != e.status) report("status", status, e.status);
			if (value != e.value) report("value", value, e.value);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [csalu_pkg::InTdataW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [csalu_pkg::OutTdataW-1:0] m_tdata;

	alu_scoreboard board = new();
	bit no_idle = 0;

	checked_signed_alu_unit dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk)
		if (s_tvalid && s_tready)
			board.note_operation(csalu_pkg::mode_t'(s_tdata[1:0]), s_tdata[65:2],
				s_tdata[129:66]);

	always @(posedge clk)
		if (m_tvalid && m_tready) board.check_result(m_tdata[63:0], m_tdata[65:64]);

	always @(negedge clk)
		if (arst_n) m_tready <= no_idle || ($urandom_range(99) >= 22);

	localparam logic [63:0] MinV = 64'h8000000000000000;
	localparam logic [63:0] MaxV = 64'h7fffffffffffffff;

	task send_op(csalu_pkg::mode_t mode, logic [63:0] a, logic [63:0] b);
		while (!no_idle && $urandom_range(99) < 22) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'b0, b, a, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = MinV;
			1: v = MaxV;
			2: v = {{56{v[63]}}, v[7:0]};
			3: v = {{32{v[63]}}, v[31:0]};
			4: v = {{40{v[63]}}, v[23:0]};
			default: ;
		endcase
		return v;
	endfunction

	task wait_drained();
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		logic [63:0] edges[6];
		edges = '{MinV, MaxV, 64'd0, 64'd1, '1, 64'h0000000100000000};
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		for (int m = 0; m < 4; m++)
			for (int i = 0; i < 6; i++)
				send_op(csalu_pkg::mode_t'(m), edges[i], edges[(i * 5 + m) % 6]);
		send_op(csalu_pkg::MODE_DIV, MinV, '1);
		send_op(csalu_pkg::MODE_ADD, MinV, MinV);
		s_tvalid <= 0;
		wait_drained();
		for (int n = 0; n < 1400; n++) begin
			no_idle = (n >= 500 && n < 700);
			send_op(csalu_pkg::mode_t'($urandom_range(3)), rand_operand(),
				($urandom_range(19) == 0) ? 64'd0 : rand_operand());
			if (n == 900) begin
				s_tvalid <= 0;
				wait_drained();
			end
		end
		s_tvalid <= 0;
		wait_drained();
		repeat (100) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end
endmodule
